FILE: rtl/core/sv39_page_table_mapper_unit_macros.svh
// assertion macros for the sv39 mapper
`ifndef SV39_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH
`define SV39_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SPTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SPTM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/sptm_pkg.sv
// ----------------------------------------------------------------------------
// sptm_pkg
// shared types, codes and constants of the sv39 page table mapper
// ----------------------------------------------------------------------------
package sptm_pkg;

  localparam int PPN_W   = 44;
  localparam int PHYS_W  = 56;
  localparam int VIRT_W  = 64;
  localparam int CNT_W   = 20;
  localparam int FLAG_W  = 8;
  localparam int STAT_W  = 3;
  localparam int VPN_W   = 9;
  localparam int PTE_W   = 64;
  localparam int ENTRIES_PER_TABLE = 512;

  localparam logic [VIRT_W-1:0] VA_LOW_END    = 64'h0000_003F_FFFF_FFFF;
  localparam logic [VIRT_W-1:0] VA_HIGH_START = 64'hFFFF_FFC0_0000_0000;
  localparam logic [PHYS_W-1:0] PAGE_BYTES    = 56'h1000;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_HOLE     = 3'd2,
    ST_OCCUPIED = 3'd3,
    ST_EXHAUST  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LOOP,
    S_RD,
    S_WAIT,
    S_EVAL,
    S_ZERO,
    S_PTR,
    S_LEAF,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;       // capture request
    logic       clr_tab;    // start clear of newly allocated table
    logic       clr_step;   // write zero, advance clear address
    logic       rd;         // issue read of walk entry
    logic       alloc;      // write pointer pte, advance level
    logic       descend;    // follow existing pointer
    logic       leaf_wr;    // write leaf, advance addresses
    logic       set_stat;
    status_t    stat;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic       null_err;
    logic       hole_err;
    logic       cnt_done;
    logic       at_leaf;
    logic       ent_zero;
    logic       pool_full;
    logic       ptr_bad;
  } sts_t;

endpackage

FILE: rtl/core/sv39_page_table_mapper_unit.sv
// ----------------------------------------------------------------------------
// sv39_page_table_mapper_unit
// builds sv39 page tables in a local pool for one map request at a time
// ----------------------------------------------------------------------------
//  channel | dir | beat content
//  in_     | in  | tdata: phys_start, virt_start, page_count, leaf_flags, global_mark
//  out_    | out | tdata: status, pages_done
//  cfg_    | in  | cfg_data: table_base_page
//
//  after reset a sweep zeroes the whole pool, in_tready low
//  per page: 3 entry reads, one per level, then the leaf write and the loop check,
//  plus a zeroing sweep of each table allocated (one ram port, one entry per cycle)
//  result beat holds until taken; next request accepted after it leaves
module sv39_page_table_mapper_unit #(
  parameter int TABLE_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // phys_start[55:0], virt_start[119:56], page_count[139:120],
  // leaf_flags[147:140], global_mark[148], zero fill to 152
  input  logic [151:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], pages_done[22:3], zero fill to 24
  output logic [23:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [43:0]  cfg_data
);

  sptm_pkg::cmd_t cmd;
  sptm_pkg::sts_t sts;
  logic [sptm_pkg::STAT_W-1:0] status;
  logic [sptm_pkg::CNT_W-1:0]  pages_done;

  assign cfg_ready = 1'b1;

  sptm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  sptm_dp #(
    .TABLE_COUNT (TABLE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .phys_in    (in_tdata[55:0]),
    .virt_in    (in_tdata[119:56]),
    .count_in   (in_tdata[139:120]),
    .flags_in   (in_tdata[147:140]),
    .glob_in    (in_tdata[148]),
    .cmd        (cmd),
    .sts        (sts),
    .status     (status),
    .pages_done (pages_done)
  );

  assign out_tdata = {1'b0, pages_done, status};

endmodule

FILE: rtl/core/sptm_ram.sv
// ----------------------------------------------------------------------------
// sptm_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module sptm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/sptm_ctrl.sv
// ----------------------------------------------------------------------------
// sptm_ctrl
// request sequencer: clear sweep, table walk, leaf write and result beat
// ----------------------------------------------------------------------------
module sptm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output sptm_pkg::cmd_t     cmd,
  input  sptm_pkg::sts_t     sts
);

  sptm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sptm_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.stat   = sptm_pkg::ST_OK;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      sptm_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = sptm_pkg::S_IDLE;
        end
      end
      sptm_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sptm_pkg::S_CHECK;
        end
      end
      sptm_pkg::S_CHECK: begin
        cmd.set_stat = 1'b1;
        if (sts.null_err) begin
          cmd.stat  = sptm_pkg::ST_NULL;
          state_nxt = sptm_pkg::S_DONE;
        end else if (sts.hole_err) begin
          cmd.stat  = sptm_pkg::ST_HOLE;
          state_nxt = sptm_pkg::S_DONE;
        end else begin
          state_nxt = sptm_pkg::S_LOOP;
        end
      end
      sptm_pkg::S_LOOP: begin
        state_nxt = sts.cnt_done ? sptm_pkg::S_DONE : sptm_pkg::S_RD;
      end
      sptm_pkg::S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = sptm_pkg::S_WAIT;
      end
      sptm_pkg::S_WAIT: begin
        state_nxt = sptm_pkg::S_EVAL;
      end
      sptm_pkg::S_EVAL: begin
        if (sts.at_leaf) begin
          if (sts.ent_zero) begin
            state_nxt = sptm_pkg::S_LEAF;
          end else begin
            cmd.set_stat = 1'b1;
            cmd.stat     = sptm_pkg::ST_OCCUPIED;
            state_nxt    = sptm_pkg::S_DONE;
          end
        end else if (sts.ent_zero) begin
          if (sts.pool_full) begin
            cmd.set_stat = 1'b1;
            cmd.stat     = sptm_pkg::ST_EXHAUST;
            state_nxt    = sptm_pkg::S_DONE;
          end else begin
            cmd.clr_tab = 1'b1;
            state_nxt   = sptm_pkg::S_ZERO;
          end
        end else if (sts.ptr_bad) begin
          cmd.set_stat = 1'b1;
          cmd.stat     = sptm_pkg::ST_EXHAUST;
          state_nxt    = sptm_pkg::S_DONE;
        end else begin
          cmd.descend = 1'b1;
          state_nxt   = sptm_pkg::S_RD;
        end
      end
      sptm_pkg::S_ZERO: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = sptm_pkg::S_PTR;
        end
      end
      sptm_pkg::S_PTR: begin
        cmd.alloc = 1'b1;
        state_nxt = sptm_pkg::S_RD;
      end
      sptm_pkg::S_LEAF: begin
        cmd.leaf_wr = 1'b1;
        state_nxt   = sptm_pkg::S_LOOP;
      end
      sptm_pkg::S_DONE: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = sptm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sptm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/sptm_dp.sv
// ----------------------------------------------------------------------------
// sptm_dp
// table store, walk address, allocator and request registers
// ----------------------------------------------------------------------------
module sptm_dp #(
  parameter int TABLE_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [sptm_pkg::PPN_W-1:0]    cfg_data,
  input  logic [sptm_pkg::PHYS_W-1:0]   phys_in,
  input  logic [sptm_pkg::VIRT_W-1:0]   virt_in,
  input  logic [sptm_pkg::CNT_W-1:0]    count_in,
  input  logic [sptm_pkg::FLAG_W-1:0]   flags_in,
  input  logic                          glob_in,
  input  sptm_pkg::cmd_t                cmd,
  output sptm_pkg::sts_t                sts,
  output logic [sptm_pkg::STAT_W-1:0]   status,
  output logic [sptm_pkg::CNT_W-1:0]    pages_done
);

  localparam int TW = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int NW = $clog2(TABLE_COUNT + 1);
  localparam int AW = TW + sptm_pkg::VPN_W;

  logic [sptm_pkg::PPN_W-1:0]  base_r;
  logic [sptm_pkg::PHYS_W-1:0] phys_r;
  logic [sptm_pkg::VIRT_W-1:0] virt_r;
  logic [sptm_pkg::CNT_W-1:0]  count_r, done_r;
  logic [sptm_pkg::FLAG_W-1:0] flags_r;
  logic                        glob_r;
  logic [sptm_pkg::STAT_W-1:0] stat_r;
  logic [NW-1:0]               next_r;
  logic [TW-1:0]               tab_r;
  logic [1:0]                  lvl_r;
  logic [AW-1:0]               clr_r;
  logic [AW-1:0]               clr_end_r;
  logic [AW-1:0]               slot_r;
  logic [AW-1:0]               addr;
  logic                        we;
  logic [sptm_pkg::PTE_W-1:0]  wdata, rdata;
  logic [sptm_pkg::VPN_W-1:0]  vpn;
  logic [sptm_pkg::PPN_W-1:0]  rel;
  logic [sptm_pkg::PPN_W-1:0]  new_ppn;

  always_comb begin
    case (lvl_r)
      2'd0:    vpn = virt_r[38:30];
      2'd1:    vpn = virt_r[29:21];
      default: vpn = virt_r[20:12];
    endcase
  end

  assign rel     = rdata[10 +: sptm_pkg::PPN_W] - base_r;
  assign new_ppn = base_r + sptm_pkg::PPN_W'(next_r);

  always_comb begin
    addr  = {tab_r, vpn};
    we    = 1'b0;
    wdata = '0;
    if (cmd.clr_step) begin
      addr = clr_r;
      we   = 1'b1;
    end else if (cmd.leaf_wr) begin
      we    = 1'b1;
      wdata = {{(sptm_pkg::PTE_W - sptm_pkg::PPN_W - 10){1'b0}},
               phys_r[12 +: sptm_pkg::PPN_W], 2'b00, flags_r};
    end
    if (cmd.alloc) begin
      addr  = slot_r;
      we    = 1'b1;
      wdata = {{(sptm_pkg::PTE_W - sptm_pkg::PPN_W - 10){1'b0}}, new_ppn,
               4'b0000, glob_r, 4'b0000, 1'b1};
    end
  end

  sptm_ram #(
    .WIDTH (sptm_pkg::PTE_W),
    .DEPTH (TABLE_COUNT * sptm_pkg::ENTRIES_PER_TABLE)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      next_r    <= NW'(1);
      clr_r     <= '0;
      clr_end_r <= '1;
      tab_r     <= '0;
      lvl_r     <= '0;
    end else begin
      if (cfg_valid) begin
        base_r <= cfg_data;
      end
      if (cmd.load) begin
        tab_r <= '0;
        lvl_r <= '0;
      end
      if (cmd.clr_tab) begin
        clr_r     <= {next_r[TW-1:0], {sptm_pkg::VPN_W{1'b0}}};
        clr_end_r <= {next_r[TW-1:0], {sptm_pkg::VPN_W{1'b1}}};
        slot_r    <= addr;
      end else if (cmd.clr_step) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.alloc) begin
        tab_r  <= next_r[TW-1:0];
        lvl_r  <= lvl_r + 2'd1;
        next_r <= next_r + NW'(1);
      end
      if (cmd.descend) begin
        tab_r <= rel[TW-1:0];
        lvl_r <= lvl_r + 2'd1;
      end
      if (cmd.leaf_wr) begin
        tab_r <= '0;
        lvl_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      phys_r  <= phys_in;
      virt_r  <= virt_in;
      count_r <= count_in;
      flags_r <= flags_in;
      glob_r  <= glob_in;
      done_r  <= '0;
      stat_r  <= sptm_pkg::ST_OK;
    end
    if (cmd.set_stat) begin
      stat_r <= cmd.stat;
    end
    if (cmd.leaf_wr) begin
      phys_r <= phys_r + sptm_pkg::PAGE_BYTES;
      virt_r <= virt_r + sptm_pkg::VIRT_W'(sptm_pkg::PAGE_BYTES);
      done_r <= done_r + sptm_pkg::CNT_W'(1);
    end
  end

  assign sts.clr_last  = (clr_r == clr_end_r);
  assign sts.null_err  = (base_r == '0) || (phys_r == '0) || (virt_r == '0);
  assign sts.hole_err  = (virt_r > sptm_pkg::VA_LOW_END) &&
                         (virt_r < sptm_pkg::VA_HIGH_START);
  assign sts.cnt_done  = (done_r == count_r);
  assign sts.at_leaf   = (lvl_r == 2'd2);
  assign sts.ent_zero  = (rdata == '0);
  assign sts.pool_full = (next_r >= NW'(TABLE_COUNT));
  assign sts.ptr_bad   = (rel >= sptm_pkg::PPN_W'(TABLE_COUNT));

  assign status     = stat_r;
  assign pages_done = done_r;

endmodule

FILE: rtl/core/sptm_checker.sv
// ----------------------------------------------------------------------------
// sptm_checker
// port-level checks of the mapper handshake and result codes
// ----------------------------------------------------------------------------
`include "sv39_page_table_mapper_unit_macros.svh"

module sptm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  `SPTM_ASSERT_IMP(a_one_side, clk, rst_n, out_tvalid, !in_tready)
  `SPTM_ASSERT_IMP(a_status_code, clk, rst_n, out_tvalid, out_tdata[2:0] <= 3'd4)
  `SPTM_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata))
  `SPTM_ASSERT_NXT(a_no_early, clk, rst_n, in_tvalid && in_tready, !out_tvalid)

endmodule

bind sv39_page_table_mapper_unit sptm_checker u_sptm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
